// File: rtl/jsu_pkg.sv
// Package for the JSON string unescaper: parser phases, result and error codes,
// character constants, the front-to-back command type and decode helpers.
// No dependencies.
package jsu_pkg;

    // Parser phases of the front end
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_STR  = 4'd1,
        PH_ESC  = 4'd2,
        PH_HEX1 = 4'd3,
        PH_BSL  = 4'd4,
        PH_U    = 4'd5,
        PH_HEX2 = 4'd6
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NOQUOTE = 3'd1;
    localparam logic [2:0] ERR_CTRL    = 3'd2;
    localparam logic [2:0] ERR_ESC     = 3'd3;
    localparam logic [2:0] ERR_HEX     = 3'd4;
    localparam logic [2:0] ERR_NOLOW   = 3'd5;
    localparam logic [2:0] ERR_SURR    = 3'd6;
    localparam logic [2:0] ERR_UNTERM  = 3'd7;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_U     = 8'h75;

    // Surrogate prefixes (top six bits of the 16-bit code unit)
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] LIM_ONE   = 16'h0080;
    localparam logic [15:0] LIM_TWO   = 16'h0800;

    // UTF-8 lead and continuation markers
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // At most one command per input: a single result, or a code point to expand.
    // nb is the number of result bytes minus one.
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  nb;
        logic [1:0]  kind;
        logic [2:0]  err;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Simple escape letter decode: {valid, byte}
    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/jsu_if.sv
// Valid/ready channel interfaces for the raw text input and the result output.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output error_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_kind,
                    input last_of_run, output ready);
endinterface

// File: rtl/jsu_front.sv
// Front end: accepts text bytes, runs the string parser and issues one command
// per input that yields results. Depends on jsu_pkg and jsu_in_if.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jsu_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hi, n_hi;

    logic        accept;
    logic [7:0]  c;
    logic        eot;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [15:0] acc_nx;
    logic        is_ws;
    logic        is_high;
    logic        is_low;
    logic        last_digit;
    logic        cmd_valid;
    logic [20:0] pair_cp;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.in_byte;
    assign eot        = i_in.end_of_text;
    assign hex        = jsu_pkg::hex_decode(c);
    assign esc        = jsu_pkg::esc_decode(c);
    assign acc_nx     = {r_acc[11:0], hex[3:0]};
    assign is_ws      = (c == jsu_pkg::CH_SPACE) || (c == jsu_pkg::CH_TAB) ||
                        (c == jsu_pkg::CH_CR) || (c == jsu_pkg::CH_LF);
    assign is_high    = (acc_nx[15:10] == jsu_pkg::SURR_HIGH);
    assign is_low     = (acc_nx[15:10] == jsu_pkg::SURR_LOW);
    assign last_digit = (r_cnt == 2'd3);
    assign pair_cp    = jsu_pkg::SUPP_BASE + {1'b0, r_hi, acc_nx[9:0]};

    // Next phase and escape registers
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hi    = r_hi;
        if (accept) begin
            if (r_phase == jsu_pkg::PH_IDLE) begin
                if (!eot && c == jsu_pkg::CH_QUOTE) begin
                    n_phase = jsu_pkg::PH_STR;
                end
            end else if (eot) begin
                n_phase = jsu_pkg::PH_IDLE;
            end else begin
                unique case (r_phase)
                    jsu_pkg::PH_STR: begin
                        if (c == jsu_pkg::CH_QUOTE || c < jsu_pkg::CH_SPACE) begin
                            n_phase = jsu_pkg::PH_IDLE;
                        end else if (c == jsu_pkg::CH_BSL) begin
                            n_phase = jsu_pkg::PH_ESC;
                        end
                    end
                    jsu_pkg::PH_ESC: begin
                        if (esc[8]) begin
                            n_phase = jsu_pkg::PH_STR;
                        end else if (c == jsu_pkg::CH_U) begin
                            n_phase = jsu_pkg::PH_HEX1;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_phase = jsu_pkg::PH_IDLE;
                        end
                    end
                    jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                        if (!hex[4]) begin
                            n_phase = jsu_pkg::PH_IDLE;
                        end else begin
                            n_acc = acc_nx;
                            n_cnt = r_cnt + 2'd1;
                            if (last_digit) begin
                                if (r_phase == jsu_pkg::PH_HEX2) begin
                                    n_phase = is_low ? jsu_pkg::PH_STR : jsu_pkg::PH_IDLE;
                                end else if (is_high) begin
                                    n_phase = jsu_pkg::PH_BSL;
                                    n_hi    = acc_nx[9:0];
                                end else if (is_low) begin
                                    n_phase = jsu_pkg::PH_IDLE;
                                end else begin
                                    n_phase = jsu_pkg::PH_STR;
                                end
                            end
                        end
                    end
                    jsu_pkg::PH_BSL: begin
                        n_phase = (c == jsu_pkg::CH_BSL) ? jsu_pkg::PH_U : jsu_pkg::PH_IDLE;
                    end
                    jsu_pkg::PH_U: begin
                        if (c == jsu_pkg::CH_U) begin
                            n_phase = jsu_pkg::PH_HEX2;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_phase = jsu_pkg::PH_IDLE;
                        end
                    end
                    default: n_phase = jsu_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Command issue
    always_comb begin
        cmd_valid  = 1'b0;
        o_cmd.cp   = '0;
        o_cmd.nb   = 2'd0;
        o_cmd.kind = jsu_pkg::KIND_ERROR;
        o_cmd.err  = jsu_pkg::ERR_NONE;
        if (r_phase == jsu_pkg::PH_IDLE) begin
            if (eot || (!is_ws && c != jsu_pkg::CH_QUOTE)) begin
                cmd_valid = 1'b1;
                o_cmd.err = jsu_pkg::ERR_NOQUOTE;
            end
        end else if (eot) begin
            cmd_valid = 1'b1;
            o_cmd.err = jsu_pkg::ERR_UNTERM;
        end else begin
            unique case (r_phase)
                jsu_pkg::PH_STR: begin
                    if (c == jsu_pkg::CH_QUOTE) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = jsu_pkg::KIND_DONE;
                    end else if (c < jsu_pkg::CH_SPACE) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_CTRL;
                    end else if (c != jsu_pkg::CH_BSL) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = jsu_pkg::KIND_DATA;
                        o_cmd.cp   = {13'd0, c};
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (esc[8]) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = jsu_pkg::KIND_DATA;
                        o_cmd.cp   = {13'd0, esc[7:0]};
                    end else if (c != jsu_pkg::CH_U) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_ESC;
                    end
                end
                jsu_pkg::PH_HEX1: begin
                    if (!hex[4]) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_HEX;
                    end else if (last_digit && is_low) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_SURR;
                    end else if (last_digit && !is_high) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = jsu_pkg::KIND_DATA;
                        o_cmd.cp   = {5'd0, acc_nx};
                        if (acc_nx < jsu_pkg::LIM_ONE) begin
                            o_cmd.nb = 2'd0;
                        end else if (acc_nx < jsu_pkg::LIM_TWO) begin
                            o_cmd.nb = 2'd1;
                        end else begin
                            o_cmd.nb = 2'd2;
                        end
                    end
                end
                jsu_pkg::PH_BSL: begin
                    if (c != jsu_pkg::CH_BSL) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_NOLOW;
                    end
                end
                jsu_pkg::PH_U: begin
                    if (c != jsu_pkg::CH_U) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_NOLOW;
                    end
                end
                jsu_pkg::PH_HEX2: begin
                    if (!hex[4]) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_HEX;
                    end else if (last_digit && !is_low) begin
                        cmd_valid = 1'b1;
                        o_cmd.err = jsu_pkg::ERR_SURR;
                    end else if (last_digit) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = jsu_pkg::KIND_DATA;
                        o_cmd.cp   = pair_cp;
                        o_cmd.nb   = 2'd3;
                    end
                end
                default: cmd_valid = 1'b0;
            endcase
        end
    end

    assign o_push = accept && cmd_valid;

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hi    <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hi    <= n_hi;
        end
    end

    // A command leaves only with an accepted byte
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_in.valid && !i_full))
        else $error("front pushed without an accepted byte");

    // A surrogate pair completion always leaves four bytes to send
    a_pair_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_phase == jsu_pkg::PH_HEX2 && !eot && o_cmd.kind == jsu_pkg::KIND_DATA)
        |-> (o_cmd.nb == 2'd3))
        else $error("surrogate pair not expanded to four bytes");

    // Digit count restarts after a completed escape
    a_cnt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !eot && hex[4] && last_digit &&
         (r_phase == jsu_pkg::PH_HEX1 || r_phase == jsu_pkg::PH_HEX2)) |=> (r_cnt == 2'd0))
        else $error("hex digit count did not wrap");

endmodule

// File: rtl/jsu_queue.sv
// Command queue between the parser front end and the UTF-8 back end.
// Depends on jsu_pkg.
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsu_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output jsu_pkg::t_head o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full      = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy out of range");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_ONE))
        else $error("occupancy did not grow on push");

endmodule

// File: rtl/jsu_back.sv
// Back end: expands the queue head into one to four result bytes, one per
// transaction, and pops the command after its last byte. Depends on jsu_pkg, jsu_out_if.
module jsu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jsu_pkg::t_head i_head,
    output logic           o_pop,
    jsu_out_if.source      o_out
);

    logic [1:0]  r_idx, n_idx;
    logic        xfer;
    logic        last;
    logic [20:0] cp;
    logic [7:0]  byte_val;

    assign cp    = i_head.cmd.cp;
    assign last  = (r_idx == i_head.cmd.nb);
    assign xfer  = o_out.valid && o_out.ready;
    assign o_pop = xfer && last;

    // Pick the UTF-8 byte for the current position
    always_comb begin
        unique case ({i_head.cmd.nb, r_idx})
            {2'd0, 2'd0}: byte_val = cp[7:0];
            {2'd1, 2'd0}: byte_val = jsu_pkg::LEAD_TWO   | {3'd0, cp[10:6]};
            {2'd1, 2'd1}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[5:0]};
            {2'd2, 2'd0}: byte_val = jsu_pkg::LEAD_THREE | {4'd0, cp[15:12]};
            {2'd2, 2'd1}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[11:6]};
            {2'd2, 2'd2}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[5:0]};
            {2'd3, 2'd0}: byte_val = jsu_pkg::LEAD_FOUR  | {5'd0, cp[20:18]};
            {2'd3, 2'd1}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[17:12]};
            {2'd3, 2'd2}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[11:6]};
            {2'd3, 2'd3}: byte_val = jsu_pkg::CONT_MARK  | {2'd0, cp[5:0]};
            default:      byte_val = 8'd0;
        endcase
    end

    assign o_out.valid       = i_head.valid;
    assign o_out.out_byte    = byte_val;
    assign o_out.kind        = i_head.cmd.kind;
    assign o_out.error_kind  = i_head.cmd.err;
    assign o_out.last_of_run = last;

    // Step through the bytes of the head command
    always_comb begin
        n_idx = r_idx;
        if (xfer) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("byte index did not restart after last byte");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_idx <= i_head.cmd.nb))
        else $error("byte index beyond command length");

    a_single_non_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head.valid && i_head.cmd.kind != jsu_pkg::KIND_DATA) |-> last)
        else $error("close or error result spans several bytes");

endmodule

// File: rtl/json_string_unescape_utf8.sv
// JSON string unescaper producing UTF-8. Takes one text byte per transaction on
// i_in and returns results on o_out, one per transaction: data bytes, a close
// marker or an error code, with last_of_run on the final result of each input.
// An input byte is taken every cycle while the command queue (QUEUE_DEPTH
// entries) has room; its command is registered in the queue and reaches o_out
// at the head. Each result byte is one output transaction, so a \u escape that
// expands to two, three or four UTF-8 bytes takes that many, absorbed by the
// queue. Uses jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic           push;
    logic           pop;
    logic           full;
    jsu_pkg::t_cmd  cmd;
    jsu_pkg::t_head head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
